// ===== sv/acm_pkg.sv =====
package acm_pkg;

  // Field widths
  localparam int COORD_W = 16;
  localparam int ANGLE_W = 17;
  localparam int OUT_W   = 16;

  // Angle handling, units of 1/128 degree
  localparam int FULL_TURN    = 46080;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int AR_W         = ANGLE_W + 1;

  // CORDIC datapath, Q24 for x/y, degrees Q16 for z
  localparam int CORDIC_STEPS = 16;
  localparam int XW           = 27;
  localparam int ZW           = 26;
  localparam int CORDIC_GAIN  = 10188014;
  localparam int ONE_Q24      = 16777216;
  localparam int ONE_Q14      = 16384;

  // Axis length and normalization
  localparam int SQ_W     = 2 * COORD_W - 1;
  localparam int SUM_W    = 2 * COORD_W;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int QW       = 25;
  localparam int DVD_W    = 56;
  localparam int GUARD_SH = 20;
  localparam logic [RAD_W-1:0] GUARD_LIMIT = 64'h0000_1000_0000_0000;
  localparam logic [RAD_W-1:0] DEGEN_LIMIT =
      (64'd1 << (2 * (COORD_W - 2))) / 64'd1000000000000;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_deg;
    logic signed [COORD_W-1:0] axis_x;
    logic signed [COORD_W-1:0] axis_y;
    logic signed [COORD_W-1:0] axis_z;
  } acm_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] r00;
    logic signed [OUT_W-1:0] r10;
    logic signed [OUT_W-1:0] r20;
    logic signed [OUT_W-1:0] r01;
    logic signed [OUT_W-1:0] r11;
    logic signed [OUT_W-1:0] r21;
    logic signed [OUT_W-1:0] r02;
    logic signed [OUT_W-1:0] r12;
    logic signed [OUT_W-1:0] r22;
    logic                    degenerate_axis;
  } acm_matrix_t;

  // Arctangent of 2^-step in degrees, Q16
  function automatic int atan_q16(input int step);
    int r;
    unique case (step)
      0:       r = 2949120;
      1:       r = 1740967;
      2:       r = 919879;
      3:       r = 466945;
      4:       r = 234379;
      5:       r = 117304;
      6:       r = 58666;
      7:       r = 29335;
      8:       r = 14668;
      9:       r = 7334;
      10:      r = 3667;
      11:      r = 1834;
      12:      r = 917;
      13:      r = 458;
      14:      r = 229;
      15:      r = 115;
      default: r = 0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/acm_delay.sv =====
module acm_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign dout = sr[DEPTH-1];

endmodule

// ===== sv/acm_cordic_cell.sv =====
module acm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [acm_pkg::XW-1:0] x_in,
  input  logic signed [acm_pkg::XW-1:0] y_in,
  input  logic signed [acm_pkg::ZW-1:0] z_in,
  output logic signed [acm_pkg::XW-1:0] x,
  output logic signed [acm_pkg::XW-1:0] y,
  output logic signed [acm_pkg::ZW-1:0] z
);
  import acm_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q16(STEP));

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ZW-1]) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - ATAN;
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + ATAN;
      end
    end
  end

endmodule

// ===== sv/acm_sqrt_cell.sv =====
module acm_sqrt_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [acm_pkg::REM_W-1:0]    rem_in,
  input  logic [acm_pkg::ROOT_W-1:0]   root_in,
  input  logic [acm_pkg::RAD_W-1:0]    rad_in,
  output logic [acm_pkg::REM_W-1:0]    rem,
  output logic [acm_pkg::ROOT_W-1:0]   root,
  output logic [acm_pkg::RAD_W-1:0]    rad
);
  import acm_pkg::*;

  logic [REM_W+1:0] r2;
  logic [REM_W+1:0] trial;
  logic             ge;

  // bring down the next two radicand bits and try root bit = 1
  assign r2    = {rem_in, rad_in[RAD_W-1 -: 2]};
  assign trial = (REM_W+2)'({root_in, 2'b01});
  assign ge    = r2 >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= ge ? REM_W'(r2 - trial) : REM_W'(r2);
      root <= {root_in[ROOT_W-2:0], ge};
      rad  <= {rad_in[RAD_W-3:0], 2'b00};
    end
  end

endmodule

// ===== sv/acm_div_cell.sv =====
module acm_div_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [acm_pkg::ROOT_W-1:0] rem_in,
  input  logic [acm_pkg::QW-1:0]     q_in,
  input  logic [acm_pkg::QW-1:0]     dvd_in,
  input  logic [acm_pkg::ROOT_W-1:0] root_in,
  output logic [acm_pkg::ROOT_W-1:0] rem,
  output logic [acm_pkg::QW-1:0]     q,
  output logic [acm_pkg::QW-1:0]     dvd,
  output logic [acm_pkg::ROOT_W-1:0] root
);
  import acm_pkg::*;

  logic [ROOT_W:0] r2;
  logic [ROOT_W:0] dsr;
  logic            ge;

  assign r2  = {rem_in, dvd_in[QW-1]};
  assign dsr = {1'b0, root_in};
  assign ge  = r2 >= dsr;

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= ge ? ROOT_W'(r2 - dsr) : ROOT_W'(r2);
      q    <= {q_in[QW-2:0], ge};
      dvd  <= {dvd_in[QW-2:0], 1'b0};
      root <= root_in;
    end
  end

endmodule

// ===== sv/axis_angle_rotation_matrix_unit.sv =====
// Axis-angle to 3x3 rotation matrix (Rodrigues form), fully pipelined.
//
// item channel: one beat carries an angle (1/128 degree) and an axis of any
// length (Q2.14). matrix channel: one beat carries the nine entries in Q1.14,
// column after column, plus degenerate_axis, set when the axis is zero and
// the identity is returned.
//
// Throughput is one beat per cycle while the output is not stalled. From an
// accepted item beat to its matrix beat there are two front stages (angle
// fold, squares and sum), a row of 32 square-root cells (one root bit each, 16
// CORDIC cells run beside the first of them), three rows of 25 divider cells
// (one quotient bit each, one row per axis component), two multiply stages and
// the output register.
//
// While a matrix beat is held by matrix_stall the whole pipeline freezes and
// item_stall is raised; nothing is dropped. Reset clears all valid bits; the
// datapath itself carries no reset.
module axis_angle_rotation_matrix_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  acm_pkg::acm_item_t   item,
  output logic                 matrix_valid,
  input  logic                 matrix_stall,
  output acm_pkg::acm_matrix_t matrix
);
  import acm_pkg::*;

  localparam int SQ_STEPS = ROOT_W;
  localparam int LAT      = 2 + SQ_STEPS + QW + 3;
  localparam int EW       = XW + 2;
  localparam int AX_W     = 3 * COORD_W + 1;
  localparam int TRIG_W   = 2 * XW;

  function automatic logic signed [XW-1:0] mulq(input logic signed [XW-1:0] a,
                                                input logic signed [XW-1:0] b);
    logic signed [2*XW-1:0] p;
    p = a * b;
    return p[XW+23:24];
  endfunction

  function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] t;
    logic signed [OUT_W-1:0] r;
    t = (v + EW'(512)) >>> 10;
    if (t > EW'(ONE_Q14)) begin
      r = OUT_W'(ONE_Q14);
    end else if (t < -EW'(ONE_Q14)) begin
      r = -OUT_W'(ONE_Q14);
    end else begin
      r = t[OUT_W-1:0];
    end
    return r;
  endfunction

  logic           en;
  logic [LAT-1:0] vld;

  assign en           = !(vld[LAT-1] && matrix_stall);
  assign item_stall   = !en;
  assign matrix_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  // Stage 1: angle into one turn, squares of the axis
  logic signed [AR_W-1:0]    ang_in;
  logic signed [AR_W-1:0]    amod_next;
  logic signed [AR_W-1:0]    amod;
  logic signed [2*COORD_W-1:0] px, py, pz;
  logic [SQ_W-1:0]           sqx, sqy, sqz;
  logic signed [COORD_W-1:0] ax, ay, az;

  assign ang_in = AR_W'(item.angle_deg);
  assign px = item.axis_x * item.axis_x;
  assign py = item.axis_y * item.axis_y;
  assign pz = item.axis_z * item.axis_z;

  always_comb begin
    priority if (ang_in < 0 && ang_in >= -AR_W'(FULL_TURN)) begin
      amod_next = ang_in + AR_W'(FULL_TURN);
    end else if (ang_in < 0) begin
      amod_next = ang_in + AR_W'(2 * FULL_TURN);
    end else if (ang_in >= AR_W'(FULL_TURN)) begin
      amod_next = ang_in - AR_W'(FULL_TURN);
    end else begin
      amod_next = ang_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amod <= amod_next;
      sqx  <= px[SQ_W-1:0];
      sqy  <= py[SQ_W-1:0];
      sqz  <= pz[SQ_W-1:0];
      ax   <= item.axis_x;
      ay   <= item.axis_y;
      az   <= item.axis_z;
    end
  end

  // Stage 2: fold to a quarter turn, axis length radicand, magnitudes
  logic [SUM_W-1:0]          sum;
  logic signed [AR_W-1:0]    half;
  logic signed [AR_W-1:0]    fold;
  logic                      neg_next;
  logic                      guard_next;
  logic signed [ZW-1:0]      z0;
  logic [RAD_W-1:0]          rad0;
  logic                      neg_c, degen, guard;
  logic [COORD_W-1:0]        magx, magy, magz;
  logic                      sgx, sgy, sgz;

  assign sum  = SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
  assign half = (amod >= AR_W'(HALF_TURN)) ? amod - AR_W'(FULL_TURN) : amod;
  assign guard_next = RAD_W'(sum) < GUARD_LIMIT;

  always_comb begin
    neg_next = 1'b0;
    priority if (half > AR_W'(QUARTER_TURN)) begin
      fold     = AR_W'(HALF_TURN) - half;
      neg_next = 1'b1;
    end else if (half < -AR_W'(QUARTER_TURN)) begin
      fold     = -AR_W'(HALF_TURN) - half;
      neg_next = 1'b1;
    end else begin
      fold = half;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0    <= ZW'(fold) <<< 9;
      neg_c <= neg_next;
      degen <= RAD_W'(sum) <= DEGEN_LIMIT;
      guard <= guard_next;
      rad0  <= guard_next ? (RAD_W'(sum) << GUARD_SH) : RAD_W'(sum);
      magx  <= ax[COORD_W-1] ? COORD_W'(~ax + 1'b1) : COORD_W'(ax);
      magy  <= ay[COORD_W-1] ? COORD_W'(~ay + 1'b1) : COORD_W'(ay);
      magz  <= az[COORD_W-1] ? COORD_W'(~az + 1'b1) : COORD_W'(az);
      sgx   <= ax[COORD_W-1];
      sgy   <= ay[COORD_W-1];
      sgz   <= az[COORD_W-1];
    end
  end

  // CORDIC cells, beside the first square-root cells
  logic signed [XW-1:0] cx [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];

  assign cx[0] = XW'(CORDIC_GAIN);
  assign cy[0] = '0;
  assign cz[0] = z0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    acm_cordic_cell #(.STEP(i)) u_cell (
      .clk  (clk),
      .en   (en),
      .x_in (cx[i]),
      .y_in (cy[i]),
      .z_in (cz[i]),
      .x    (cx[i+1]),
      .y    (cy[i+1]),
      .z    (cz[i+1])
    );
  end

  // Square-root cells
  logic [REM_W-1:0]  srem  [SQ_STEPS+1];
  logic [ROOT_W-1:0] sroot [SQ_STEPS+1];
  logic [RAD_W-1:0]  srad  [SQ_STEPS+1];

  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = rad0;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    acm_sqrt_cell u_cell (
      .clk     (clk),
      .en      (en),
      .rem_in  (srem[i]),
      .root_in (sroot[i]),
      .rad_in  (srad[i]),
      .rem     (srem[i+1]),
      .root    (sroot[i+1]),
      .rad     (srad[i+1])
    );
  end

  // Side data delayed to meet the cell rows
  logic [AX_W-1:0]   ax_d;
  logic [4:0]        flag_d;
  logic [TRIG_W-1:0] trig_d;

  acm_delay #(.WIDTH(AX_W), .DEPTH(SQ_STEPS)) u_dly_axis (
    .clk  (clk),
    .en   (en),
    .din  ({guard, magx, magy, magz}),
    .dout (ax_d)
  );

  acm_delay #(.WIDTH(5), .DEPTH(SQ_STEPS + QW)) u_dly_flag (
    .clk  (clk),
    .en   (en),
    .din  ({neg_c, degen, sgx, sgy, sgz}),
    .dout (flag_d)
  );

  acm_delay #(.WIDTH(TRIG_W), .DEPTH(SQ_STEPS - CORDIC_STEPS + QW)) u_dly_trig (
    .clk  (clk),
    .en   (en),
    .din  ({cx[CORDIC_STEPS], cy[CORDIC_STEPS]}),
    .dout (trig_d)
  );

  // Divider cells, one row per axis component
  logic [COORD_W-1:0] mag_d [3];
  logic [ROOT_W-1:0]  drem  [3][QW+1];
  logic [QW-1:0]      dq    [3][QW+1];
  logic [QW-1:0]      ddvd  [3][QW+1];
  logic [ROOT_W-1:0]  droot [3][QW+1];

  assign mag_d[0] = ax_d[3*COORD_W-1 -: COORD_W];
  assign mag_d[1] = ax_d[2*COORD_W-1 -: COORD_W];
  assign mag_d[2] = ax_d[COORD_W-1:0];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [DVD_W-1:0] dvd_full;

    // the radicand was scaled by 2^GUARD_SH, so the root carries half of it
    assign dvd_full = ax_d[AX_W-1] ? (DVD_W'(mag_d[l]) << (24 + GUARD_SH / 2))
                                   : (DVD_W'(mag_d[l]) << 24);
    assign drem[l][0]  = ROOT_W'(dvd_full[DVD_W-1:QW]);
    assign dq[l][0]    = '0;
    assign ddvd[l][0]  = dvd_full[QW-1:0];
    assign droot[l][0] = sroot[SQ_STEPS];

    for (genvar i = 0; i < QW; i++) begin : g_div
      acm_div_cell u_cell (
        .clk     (clk),
        .en      (en),
        .rem_in  (drem[l][i]),
        .q_in    (dq[l][i]),
        .dvd_in  (ddvd[l][i]),
        .root_in (droot[l][i]),
        .rem     (drem[l][i+1]),
        .q       (dq[l][i+1]),
        .dvd     (ddvd[l][i+1]),
        .root    (droot[l][i+1])
      );
    end
  end

  // Multiply stage 1: u*u, u*s, cosine terms
  logic signed [XW-1:0] ux, uy, uz, uqx, uqy, uqz;
  logic signed [XW-1:0] tx, ty;
  logic signed [XW-1:0] c1, k1, pxx, pyy, pzz, pxy, pxz, pyz, sx1, sy1, sz1;
  logic                 dg1;

  assign tx  = trig_d[TRIG_W-1 -: XW];
  assign ty  = trig_d[XW-1:0];
  assign uqx = signed'(XW'(dq[0][QW]));
  assign uqy = signed'(XW'(dq[1][QW]));
  assign uqz = signed'(XW'(dq[2][QW]));
  assign ux  = flag_d[2] ? -uqx : uqx;
  assign uy  = flag_d[1] ? -uqy : uqy;
  assign uz  = flag_d[0] ? -uqz : uqz;

  always_ff @(posedge clk) begin
    if (en) begin
      c1  <= flag_d[4] ? -tx : tx;
      k1  <= XW'(ONE_Q24) - (flag_d[4] ? -tx : tx);
      pxx <= mulq(ux, ux);
      pyy <= mulq(uy, uy);
      pzz <= mulq(uz, uz);
      pxy <= mulq(uy, ux);
      pxz <= mulq(uz, ux);
      pyz <= mulq(uz, uy);
      sx1 <= mulq(ux, ty);
      sy1 <= mulq(uy, ty);
      sz1 <= mulq(uz, ty);
      dg1 <= flag_d[3];
    end
  end

  // Multiply stage 2: scale by one minus cosine
  logic signed [XW-1:0] c2, qxx, qyy, qzz, qxy, qxz, qyz, sx2, sy2, sz2;
  logic                 dg2;

  always_ff @(posedge clk) begin
    if (en) begin
      c2  <= c1;
      qxx <= mulq(pxx, k1);
      qyy <= mulq(pyy, k1);
      qzz <= mulq(pzz, k1);
      qxy <= mulq(pxy, k1);
      qxz <= mulq(pxz, k1);
      qyz <= mulq(pyz, k1);
      sx2 <= sx1;
      sy2 <= sy1;
      sz2 <= sz1;
      dg2 <= dg1;
    end
  end

  // Output stage: sum, round, saturate; identity for a zero axis
  acm_matrix_t res;

  always_comb begin
    if (dg2) begin
      res                 = '0;
      res.r00             = OUT_W'(ONE_Q14);
      res.r11             = OUT_W'(ONE_Q14);
      res.r22             = OUT_W'(ONE_Q14);
      res.degenerate_axis = 1'b1;
    end else begin
      res.r00 = to_q14(EW'(c2) + EW'(qxx));
      res.r10 = to_q14(EW'(qxy) + EW'(sz2));
      res.r20 = to_q14(EW'(qxz) - EW'(sy2));
      res.r01 = to_q14(EW'(qxy) - EW'(sz2));
      res.r11 = to_q14(EW'(c2) + EW'(qyy));
      res.r21 = to_q14(EW'(qyz) + EW'(sx2));
      res.r02 = to_q14(EW'(qxz) + EW'(sy2));
      res.r12 = to_q14(EW'(qyz) - EW'(sx2));
      res.r22 = to_q14(EW'(c2) + EW'(qzz));
      res.degenerate_axis = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      matrix <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_degen_identity: assert property (@(posedge clk) disable iff (rst)
    matrix_valid && matrix.degenerate_axis |->
      matrix.r00 == OUT_W'(ONE_Q14) && matrix.r10 == '0 && matrix.r11 == OUT_W'(ONE_Q14))
    else $error("degenerate beat is not the identity");

  a_diag_sat: assert property (@(posedge clk) disable iff (rst)
    matrix_valid |-> matrix.r00 <= OUT_W'(ONE_Q14) && matrix.r00 >= -OUT_W'(ONE_Q14) &&
                     matrix.r22 <= OUT_W'(ONE_Q14) && matrix.r22 >= -OUT_W'(ONE_Q14))
    else $error("diagonal entry beyond saturation bound");

  a_reset_clear: assert property (@(posedge clk) rst |=> !matrix_valid && vld == '0)
    else $error("valid bits survive reset");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    matrix_valid && matrix_stall |=> $stable(vld))
    else $error("pipeline moved while output stalled");
`endif

endmodule

// ===== tb/tb_axis_angle_rotation_matrix_unit.sv =====
`timescale 1ns / 1ps

import acm_pkg::*;

class rotation_scoreboard;
  acm_matrix_t pending_matrices[$];
  int errors;
  int items_seen;
  int matrices_seen;
  int degenerate_seen;

  function new();
    errors = 0;
    items_seen = 0;
    matrices_seen = 0;
    degenerate_seen = 0;
  endfunction

  function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function longint fx_mul(longint a, longint b);
    return (a * b) >>> 24;
  endfunction

  function logic [OUT_W-1:0] to_q14(longint v);
    longint q;
    q = (v + 512) >>> 10;
    if (q > ONE_Q14) q = ONE_Q14;
    if (q < -ONE_Q14) q = -ONE_Q14;
    return q[OUT_W-1:0];
  endfunction

  function longint unit_part(longint a, int sh, longint unsigned root);
    longint unsigned mag;
    longint q;
    mag = (a < 0) ? -a : a;
    q = (mag << sh) / root;
    return (a < 0) ? -q : q;
  endfunction

  function acm_matrix_t rotation_of(acm_item_t it);
    longint ang, ax, ay, az, x, y, z, c, s, k, ux, uy, uz, dx, dy;
    longint unsigned sum, root;
    bit neg_cos;
    int sh;
    longint e[9];
    acm_matrix_t m;
    ax = it.axis_x;
    ay = it.axis_y;
    az = it.axis_z;
    m = '0;
    sum = ax * ax + ay * ay + az * az;
    if (sum <= DEGEN_LIMIT) begin
      m.r00 = OUT_W'(ONE_Q14);
      m.r11 = OUT_W'(ONE_Q14);
      m.r22 = OUT_W'(ONE_Q14);
      m.degenerate_axis = 1'b1;
      return m;
    end
    // fold the angle into [-90, 90] degrees, remember a flipped cosine
    neg_cos = 0;
    ang = longint'(it.angle_deg) % FULL_TURN;
    if (ang < 0) ang += FULL_TURN;
    if (ang >= HALF_TURN) ang -= FULL_TURN;
    if (ang > QUARTER_TURN) begin
      ang = HALF_TURN - ang;
      neg_cos = 1;
    end else if (ang < -QUARTER_TURN) begin
      ang = -HALF_TURN - ang;
      neg_cos = 1;
    end
    x = CORDIC_GAIN;
    y = 0;
    z = ang * 512;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_q16(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_q16(i);
      end
    end
    c = neg_cos ? -x : x;
    s = y;
    k = ONE_Q24 - c;
    sh = (sum < GUARD_LIMIT) ? GUARD_SH : 0;
    root = int_sqrt(sum << sh);
    ux = unit_part(ax, 24 + sh / 2, root);
    uy = unit_part(ay, 24 + sh / 2, root);
    uz = unit_part(az, 24 + sh / 2, root);
    e[0] = c + fx_mul(fx_mul(ux, ux), k);
    e[1] = fx_mul(fx_mul(uy, ux), k) + fx_mul(uz, s);
    e[2] = fx_mul(fx_mul(uz, ux), k) - fx_mul(uy, s);
    e[3] = fx_mul(fx_mul(ux, uy), k) - fx_mul(uz, s);
    e[4] = c + fx_mul(fx_mul(uy, uy), k);
    e[5] = fx_mul(fx_mul(uz, uy), k) + fx_mul(ux, s);
    e[6] = fx_mul(fx_mul(ux, uz), k) + fx_mul(uy, s);
    e[7] = fx_mul(fx_mul(uy, uz), k) - fx_mul(ux, s);
    e[8] = c + fx_mul(fx_mul(uz, uz), k);
    m.r00 = to_q14(e[0]);
    m.r10 = to_q14(e[1]);
    m.r20 = to_q14(e[2]);
    m.r01 = to_q14(e[3]);
    m.r11 = to_q14(e[4]);
    m.r21 = to_q14(e[5]);
    m.r02 = to_q14(e[6]);
    m.r12 = to_q14(e[7]);
    m.r22 = to_q14(e[8]);
    return m;
  endfunction

  function void note_item(acm_item_t it);
    acm_matrix_t m;
    m = rotation_of(it);
    items_seen++;
    if (m.degenerate_axis) degenerate_seen++;
    pending_matrices.push_back(m);
  endfunction

  function void field_cmp(string name, logic signed [OUT_W-1:0] exp_v,
                          logic signed [OUT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_matrix(acm_matrix_t got);
    acm_matrix_t w;
    matrices_seen++;
    if (pending_matrices.size() == 0) begin
      $error("matrix beat with nothing pending");
      errors++;
      return;
    end
    w = pending_matrices.pop_front();
    field_cmp("r00", w.r00, got.r00);
    field_cmp("r10", w.r10, got.r10);
    field_cmp("r20", w.r20, got.r20);
    field_cmp("r01", w.r01, got.r01);
    field_cmp("r11", w.r11, got.r11);
    field_cmp("r21", w.r21, got.r21);
    field_cmp("r02", w.r02, got.r02);
    field_cmp("r12", w.r12, got.r12);
    field_cmp("r22", w.r22, got.r22);
    if (w.degenerate_axis !== got.degenerate_axis) begin
      $error("degenerate_axis: expected %0d, got %0d", w.degenerate_axis,
             got.degenerate_axis);
      errors++;
    end
  endfunction
endclass

module tb_axis_angle_rotation_matrix_unit;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 1430;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  acm_item_t   item;
  logic        matrix_valid;
  logic        matrix_stall;
  acm_matrix_t matrix;

  rotation_scoreboard sb;
  bit no_idle;
  int idle_cycles;

  axis_angle_rotation_matrix_unit dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .matrix_valid(matrix_valid),
    .matrix_stall(matrix_stall),
    .matrix(matrix)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // sample both channels at the edge, before any update lands
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (matrix_valid && !matrix_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (item_valid && !item_stall) begin
        sb.note_item(item);
      end
      if (matrix_valid && !matrix_stall) begin
        sb.check_matrix(matrix);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d matrices pending",
                 sb.pending_matrices.size());
        $display("tb_axis_angle_rotation_matrix_unit: errors");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic send_item(acm_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_fields(int ang, int ax, int ay, int az);
    acm_item_t it;
    it.angle_deg = ANGLE_W'(ang);
    it.axis_x = COORD_W'(ax);
    it.axis_y = COORD_W'(ay);
    it.axis_z = COORD_W'(az);
    send_item(it);
  endtask

  function automatic int rand_coord();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return 0;
    if (pick < 5) return $urandom_range(0, 8) - 4;
    if (pick < 6) return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  function automatic int rand_angle();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      return ($urandom_range(0, 8) - 4) * QUARTER_TURN + $urandom_range(0, 2) - 1;
    if (pick == 1) return ($urandom_range(0, 1) != 0) ? FULL_TURN : -FULL_TURN;
    return $urandom_range(0, 2 * FULL_TURN) - FULL_TURN;
  endfunction

  task automatic drain();
    while (sb.pending_matrices.size() != 0) @(posedge clk);
  endtask

  // receiver: hold stall for a drawn number of cycles, then take one beat
  initial begin
    int n;
    matrix_stall = 1'b1;
    @(negedge rst);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        matrix_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      matrix_stall <= 1'b0;
      @(posedge clk);
      while (!matrix_valid) @(posedge clk);
    end
  end

  initial begin
    int ax, ay, az;
    sb = new();
    idle_cycles = 0;
    no_idle = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero axis, then folding points of the angle on unit x, y and z axes, then tiny and extreme axes
    send_fields(0, 0, 0, 0);
    send_fields(FULL_TURN, 0, 0, 0);
    send_fields(-FULL_TURN, 0, 0, 0);
    send_fields(0, 16384, 0, 0);
    send_fields(QUARTER_TURN, 16384, 0, 0);
    send_fields(QUARTER_TURN + 1, 16384, 0, 0);
    send_fields(-QUARTER_TURN, 0, 16384, 0);
    send_fields(-QUARTER_TURN - 1, 0, 16384, 0);
    send_fields(HALF_TURN, 0, 0, 16384);
    send_fields(HALF_TURN - 1, 0, 0, 16384);
    send_fields(-HALF_TURN, 0, 0, -16384);
    send_fields(3 * QUARTER_TURN, 1, 0, 0);
    send_fields(FULL_TURN, 0, -1, 0);
    send_fields(-FULL_TURN, 0, 0, 1);
    send_fields(5000, 32767, 32767, 32767);
    send_fields(-5000, -32768, -32768, -32768);
    send_fields(12345, -32768, 32767, 0);
    send_fields(-1, 1, 1, 1);
    send_fields(1, -1, -1, -1);
    send_fields(30000, 0, -32768, 32767);
    item_valid <= 1'b0;
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (i == RANDOM_ITEMS / 2) begin
        item_valid <= 1'b0;
        drain();
        @(posedge clk);
      end
      ax = rand_coord();
      ay = rand_coord();
      az = rand_coord();
      send_fields(rand_angle(), ax, ay, az);
    end
    item_valid <= 1'b0;
    drain();
    repeat (80) @(posedge clk);

    $display("covered %0d items (%0d zero-axis), %0d matrices checked",
             sb.items_seen, sb.degenerate_seen, sb.matrices_seen);
    $display("angle folds at multiples of 90 degrees and axis extremes included");
    if (sb.errors == 0 && sb.pending_matrices.size() == 0) begin
      $display("tb_axis_angle_rotation_matrix_unit: clean");
    end else begin
      $display("%0d mismatches, %0d matrices never arrived", sb.errors,
               sb.pending_matrices.size());
      $display("tb_axis_angle_rotation_matrix_unit: errors");
    end
    $finish;
  end
endmodule

// ===== axis_angle_rotation_matrix_unit.f =====
sv/acm_pkg.sv
sv/acm_delay.sv
sv/acm_cordic_cell.sv
sv/acm_sqrt_cell.sv
sv/acm_div_cell.sv
sv/axis_angle_rotation_matrix_unit.sv
tb/tb_axis_angle_rotation_matrix_unit.sv
